/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros - concurrent assertion helpers
// Clocked assertions with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, ck, rs, prop) \
  label: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("assertion failed");
`define ASSERT_ANY(label, ck, prop) \
  label: assert property (@(posedge ck) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, ck, rs, prop)
`define ASSERT_ANY(label, ck, prop)
`endif

`endif

/* src/drf_pkg.sv */
// ----------------------------------------------------------------------------
// drf_pkg - delimited record framer package
// Shared types and constants for the framer front, queue and back.
// ----------------------------------------------------------------------------
package drf_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_OVERLONG  = 2'd2;
  localparam logic [1:0] ST_CUT_EOS   = 2'd3;

  localparam logic [7:0] REG_DELIMITER = 8'd0;
  localparam logic [7:0] REG_STRIP_CR  = 8'd1;
  localparam logic [7:0] REG_MAX_LEN   = 8'd2;
  localparam logic [7:0] REG_TRUNCATE  = 8'd3;

  localparam int SLOT_CR   = 0;
  localparam int SLOT_BYTE = 1;
  localparam int SLOT_END  = 2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]  delimiter;
    logic        strip_cr;
    logic [15:0] max_len;
    logic        truncate_on_max;
  } cfg_t;

  // one accepted item: which results it causes and their payload
  typedef struct packed {
    logic [2:0] mask;
    logic [7:0] data;
    logic [1:0] status;
  } plan_t;

endpackage

/* src/drf_front.sv */
// ----------------------------------------------------------------------------
// drf_front - framer front end
// Accepts stream words, tracks record state and plans the results of each.
// ----------------------------------------------------------------------------
module drf_front #(
  parameter int LEN_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             kind,
  input  logic [7:0]       data_byte,
  input  drf_pkg::cfg_t    cfg,
  output logic             q_push,
  output drf_pkg::plan_t   q_data,
  input  logic             q_full
);
  import drf_pkg::*;

  localparam int CW = (LEN_BITS > 16) ? LEN_BITS : 16;

  logic [LEN_BITS-1:0] record_count, record_count_next;
  logic                cr_held, cr_held_next;
  logic                dropping, dropping_next;
  logic                skip_next, skip_next_next;

  logic [LEN_BITS-1:0] cnt_sat;
  logic                is_delim;
  logic                hold;
  logic                lim;
  logic                accept;
  plan_t               plan;

  assign full     = q_full;
  assign accept   = push && !q_full;
  assign is_delim = (data_byte == cfg.delimiter);
  assign cnt_sat  = (record_count == {LEN_BITS{1'b1}}) ? record_count
                                                       : record_count + LEN_BITS'(1);
  assign hold     = cfg.strip_cr && (data_byte == CH_CR);
  assign lim      = (cfg.max_len != 16'd0) && (CW'(cnt_sat) >= CW'(cfg.max_len));

  always_comb begin
    plan              = '0;
    plan.data         = data_byte;
    record_count_next = record_count;
    cr_held_next      = cr_held;
    dropping_next     = dropping;
    skip_next_next    = skip_next;
    priority if (kind) begin
      plan.mask[SLOT_CR]  = cr_held;
      plan.mask[SLOT_END] = (record_count != '0) || cr_held;
      plan.status         = ST_CUT_EOS;
      record_count_next   = '0;
      cr_held_next        = 1'b0;
      dropping_next       = 1'b0;
      skip_next_next      = 1'b0;
    end else if (skip_next) begin
      skip_next_next = 1'b0;
    end else if (dropping) begin
      if (is_delim) begin
        dropping_next = 1'b0;
      end
    end else if (is_delim) begin
      plan.mask[SLOT_END] = 1'b1;
      plan.status         = ST_COMPLETE;
      cr_held_next        = 1'b0;
      record_count_next   = '0;
    end else begin
      plan.mask[SLOT_CR]   = cr_held;
      plan.mask[SLOT_BYTE] = !hold || lim;
      plan.mask[SLOT_END]  = lim;
      plan.status          = cfg.truncate_on_max ? ST_TRUNCATED : ST_OVERLONG;
      cr_held_next         = hold && !lim;
      record_count_next    = lim ? '0 : cnt_sat;
      if (lim) begin
        skip_next_next = cfg.truncate_on_max;
        dropping_next  = !cfg.truncate_on_max;
      end
    end
  end

  assign q_push = accept && (plan.mask != 3'd0);
  assign q_data = plan;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_count <= '0;
      cr_held      <= 1'b0;
      dropping     <= 1'b0;
      skip_next    <= 1'b0;
    end else if (accept) begin
      record_count <= record_count_next;
      cr_held      <= cr_held_next;
      dropping     <= dropping_next;
      skip_next    <= skip_next_next;
    end
  end

endmodule

/* src/drf_queue.sv */
// ----------------------------------------------------------------------------
// drf_queue - plan queue
// Short FIFO of planned items between the front and the back.
// ----------------------------------------------------------------------------
module drf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  drf_pkg::plan_t wr_data,
  output logic           full,
  input  logic           pop,
  output drf_pkg::plan_t rd_data,
  output logic           empty
);
  import drf_pkg::*;

  plan_t              slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/drf_back.sv */
// ----------------------------------------------------------------------------
// drf_back - framer back end
// Expands planned items into result words, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drf_back (
  input  logic           clk,
  input  logic           rst,
  input  drf_pkg::plan_t q_data,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           byte_valid,
  output logic           record_end,
  output logic [1:0]     status,
  output logic           last
);
  import drf_pkg::*;

  logic [2:0] cur_mask;
  logic [7:0] cur_data;
  logic [1:0] cur_status;
  logic       o_valid;
  logic [2:0] rem;
  logic       adv;
  logic       emit;
  logic       load;

  assign adv   = !o_valid || pop;
  assign emit  = adv && (cur_mask != 3'd0);
  assign rem   = cur_mask & (cur_mask - 3'd1);
  assign load  = (cur_mask == 3'd0) || (emit && (rem == 3'd0));
  assign q_pop = load && !q_empty;
  assign empty = !o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid  <= 1'b0;
      cur_mask <= '0;
    end else begin
      if (adv) begin
        o_valid <= emit;
      end
      if (q_pop) begin
        cur_mask <= q_data.mask;
      end else if (emit) begin
        cur_mask <= rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_data   <= q_data.data;
      cur_status <= q_data.status;
    end
    if (emit) begin
      last <= (rem == 3'd0);
      priority if (cur_mask[SLOT_CR]) begin
        out_byte   <= CH_CR;
        byte_valid <= 1'b1;
        record_end <= 1'b0;
        status     <= ST_COMPLETE;
      end else if (cur_mask[SLOT_BYTE]) begin
        out_byte   <= cur_data;
        byte_valid <= 1'b1;
        record_end <= 1'b0;
        status     <= ST_COMPLETE;
      end else begin
        out_byte   <= 8'd0;
        byte_valid <= 1'b0;
        record_end <= 1'b1;
        status     <= cur_status;
      end
    end
  end

  `ASSERT_CLK(a_pop_nonempty, clk, rst, q_pop |-> !q_empty)
  `ASSERT_CLK(a_rest_waits, clk, rst, (o_valid && !last) |-> (cur_mask != 3'd0))
  `ASSERT_CLK(a_emit_shows, clk, rst, emit |=> o_valid)
  `ASSERT_CLK(a_one_kind, clk, rst, o_valid |-> (byte_valid != record_end))

endmodule

/* src/delimited_record_framer_unit.sv */
// ----------------------------------------------------------------------------
// delimited_record_framer_unit - delimited record framer
// Splits a byte stream into records with CR strip, length limit and status.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  input    push / full           kind, data_byte
//  result   empty / pop           out_byte, byte_valid, record_end, status, last
//  config   cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One input word per cycle is classified by the front while full is low; each
//  input word yields 0 to 3 result words, which the back emits in turn.
//  An accepted word goes into the plan queue, then into the back's current item, then to the registered result.
//  rst is synchronous; it restores register defaults and clears record state.
//  full rises only when the four-entry plan queue is full; results hold on stall.
module delimited_record_framer_unit #(
  parameter int LEN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        record_end,
  output logic [1:0]  status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import drf_pkg::*;

  cfg_t  cfg;
  logic  q_push;
  plan_t q_wr_data;
  logic  q_full;
  logic  q_pop;
  plan_t q_rd_data;
  logic  q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter       <= CH_LF;
      cfg.strip_cr        <= 1'b1;
      cfg.max_len         <= 16'd0;
      cfg.truncate_on_max <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELIMITER: cfg.delimiter       <= cfg_data[7:0];
        REG_STRIP_CR:  cfg.strip_cr        <= cfg_data[0];
        REG_MAX_LEN:   cfg.max_len         <= cfg_data;
        REG_TRUNCATE:  cfg.truncate_on_max <= cfg_data[0];
        default:       cfg                 <= cfg;
      endcase
    end
  end

  drf_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .data_byte (data_byte),
    .cfg       (cfg),
    .q_push    (q_push),
    .q_data    (q_wr_data),
    .q_full    (q_full)
  );

  drf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  drf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (q_rd_data),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .record_end (record_end),
    .status     (status),
    .last       (last)
  );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - delimited record framer unit
// Feeds byte and end-of-stream words through the push/full queue port, pops
// result words at an irregular rate and checks each one, field by field,
// against a cycle-free predictor of the framer. A short table of directed
// words comes first, then random phases under several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import drf_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 24;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 20;

  typedef struct packed {
    logic [7:0] out_b;
    logic       b_valid;
    logic       r_end;
    logic [1:0] stat;
    logic       lst;
  } frame_word_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_op_e;

  typedef struct packed {
    row_op_e     op;
    logic        eos;
    logic [7:0]  dat;
    logic [7:0]  reg_idx;
    logic [15:0] reg_val;
    logic        typed;
    logic [1:0]  n_typed;
    frame_word_t w0;
    frame_word_t w1;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        kind = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        record_end;
  logic [1:0]  status;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'h00;
  logic [15:0] cfg_data = 16'h0000;

  delimited_record_framer_unit #(.LEN_BITS(16)) DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .data_byte  (data_byte),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .record_end (record_end),
    .status     (status),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // framer state as seen by the predictor
  logic [7:0]  fr_delim;
  logic        fr_strip;
  logic [15:0] fr_max;
  logic        fr_trunc;
  logic [15:0] fr_count;
  logic        fr_cr_hold;
  logic        fr_dropping;
  logic        fr_skip;

  frame_word_t step_out [0:2];
  int          step_n;
  frame_word_t pending_words [$];
  stim_row_t   dir_tab [$];
  int          errors = 0;
  int          burst_left = 0;
  int          rx_mode = 0;
  int          rx_cycle = 0;
  int          idle_cycles = 0;

  function automatic frame_word_t data_word(input logic [7:0] b, input logic l);
    frame_word_t w;
    w = '0;
    w.out_b = b;
    w.b_valid = 1'b1;
    w.lst = l;
    return w;
  endfunction

  function automatic frame_word_t mark_word(input logic [1:0] st, input logic l);
    frame_word_t w;
    w = '0;
    w.r_end = 1'b1;
    w.stat = st;
    w.lst = l;
    return w;
  endfunction

  function automatic void emit(input frame_word_t w);
    step_out[step_n] = w;
    step_n++;
  endfunction

  function automatic void frame_step(input logic eos, input logic [7:0] d);
    logic any_taken;
    step_n = 0;
    if (eos) begin
      any_taken = (fr_count != 16'd0) || fr_cr_hold;
      if (fr_cr_hold) emit(data_word(CH_CR, 1'b0));
      if (any_taken) emit(mark_word(ST_CUT_EOS, 1'b0));
      fr_count = 16'd0;
      fr_cr_hold = 1'b0;
      fr_dropping = 1'b0;
      fr_skip = 1'b0;
    end else if (fr_skip) begin
      fr_skip = 1'b0;
    end else if (fr_dropping) begin
      if (d == fr_delim) fr_dropping = 1'b0;
    end else if (d == fr_delim) begin
      fr_cr_hold = 1'b0;
      emit(mark_word(ST_COMPLETE, 1'b0));
      fr_count = 16'd0;
    end else begin
      if (fr_cr_hold) begin
        emit(data_word(CH_CR, 1'b0));
        fr_cr_hold = 1'b0;
      end
      if (fr_count != 16'hFFFF) fr_count++;
      if (fr_strip && d == CH_CR) fr_cr_hold = 1'b1;
      else emit(data_word(d, 1'b0));
      if (fr_max != 16'd0 && fr_count >= fr_max) begin
        if (fr_cr_hold) begin
          emit(data_word(CH_CR, 1'b0));
          fr_cr_hold = 1'b0;
        end
        if (fr_trunc) begin
          emit(mark_word(ST_TRUNCATED, 1'b0));
          fr_skip = 1'b1;
        end else begin
          emit(mark_word(ST_OVERLONG, 1'b0));
          fr_dropping = 1'b1;
        end
        fr_count = 16'd0;
      end
    end
    if (step_n > 0) step_out[step_n - 1].lst = 1'b1;
  endfunction

  function automatic stim_row_t t_word(input logic eos, input logic [7:0] d);
    stim_row_t r;
    r = '0;
    r.op = ROW_WORD;
    r.eos = eos;
    r.dat = d;
    return r;
  endfunction

  function automatic stim_row_t t_chk(input logic eos, input logic [7:0] d,
                                      input logic [1:0] n, input frame_word_t w0,
                                      input frame_word_t w1);
    stim_row_t r;
    r = t_word(eos, d);
    r.typed = 1'b1;
    r.n_typed = n;
    r.w0 = w0;
    r.w1 = w1;
    return r;
  endfunction

  function automatic stim_row_t t_reg(input logic [7:0] idx, input logic [15:0] val);
    stim_row_t r;
    r = '0;
    r.op = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic send_word(input logic eos, input logic [7:0] d, input logic typed,
                           input logic [1:0] n_typed, input frame_word_t w0,
                           input frame_word_t w1);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    push <= 1'b1;
    kind <= eos;
    data_byte <= d;
    do @(posedge clk); while (full);
    frame_step(eos, d);
    if (typed) begin
      if (n_typed > 0) pending_words.push_back(w0);
      if (n_typed > 1) pending_words.push_back(w1);
    end else begin
      for (int i = 0; i < step_n; i++) pending_words.push_back(step_out[i]);
    end
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DELIMITER: fr_delim = val[7:0];
      REG_STRIP_CR:  fr_strip = val[0];
      REG_MAX_LEN:   fr_max = val;
      REG_TRUNCATE:  fr_trunc = val[0];
      default: ;
    endcase
  endtask

  // result side: check the popped word, then pick the next pop
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected word", {8'h00, out_byte}, 16'h0000);
        end else begin
          if (out_byte !== pending_words[0].out_b)
            report_mismatch("out_byte", {8'h00, out_byte},
                            {8'h00, pending_words[0].out_b});
          if (byte_valid !== pending_words[0].b_valid)
            report_mismatch("byte_valid", {15'd0, byte_valid},
                            {15'd0, pending_words[0].b_valid});
          if (record_end !== pending_words[0].r_end)
            report_mismatch("record_end", {15'd0, record_end},
                            {15'd0, pending_words[0].r_end});
          if (status !== pending_words[0].stat)
            report_mismatch("status", {14'd0, status}, {14'd0, pending_words[0].stat});
          if (last !== pending_words[0].lst)
            report_mismatch("last", {15'd0, last}, {15'd0, pending_words[0].lst});
          void'(pending_words.pop_front());
        end
      end
      rx_cycle++;
      if (rx_cycle % 53 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 7) == 0);
        default: pop <= (rx_cycle % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** delimited_record_framer_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t   row;
    logic [7:0]  dlm;
    logic        stp;
    logic [15:0] mx;
    logic        trn;
    logic        eos;
    logic [7:0]  d;
    int          r;

    fr_delim = CH_LF;
    fr_strip = 1'b1;
    fr_max = 16'd0;
    fr_trunc = 1'b0;
    fr_count = 16'd0;
    fr_cr_hold = 1'b0;
    fr_dropping = 1'b0;
    fr_skip = 1'b0;

    dir_tab.push_back(t_chk(1'b0, 8'h00, 2'd1, data_word(8'h00, 1'b1), '0));
    dir_tab.push_back(t_chk(1'b0, 8'hFF, 2'd1, data_word(8'hFF, 1'b1), '0));
    dir_tab.push_back(t_chk(1'b0, CH_LF, 2'd1, mark_word(ST_COMPLETE, 1'b1), '0));
    dir_tab.push_back(t_chk(1'b0, CH_LF, 2'd1, mark_word(ST_COMPLETE, 1'b1), '0));
    dir_tab.push_back(t_chk(1'b0, CH_CR, 2'd0, '0, '0));
    dir_tab.push_back(t_chk(1'b0, CH_LF, 2'd1, mark_word(ST_COMPLETE, 1'b1), '0));
    dir_tab.push_back(t_word(1'b0, CH_CR));
    dir_tab.push_back(t_word(1'b0, 8'h41));
    dir_tab.push_back(t_word(1'b1, 8'hFF));
    dir_tab.push_back(t_chk(1'b1, 8'h00, 2'd0, '0, '0));
    dir_tab.push_back(t_word(1'b0, CH_CR));
    dir_tab.push_back(t_chk(1'b1, 8'hAA, 2'd2, data_word(CH_CR, 1'b0),
                            mark_word(ST_CUT_EOS, 1'b1)));
    dir_tab.push_back(t_reg(REG_MAX_LEN, 16'd2));
    dir_tab.push_back(t_reg(REG_TRUNCATE, 16'd0));
    dir_tab.push_back(t_word(1'b0, 8'h61));
    dir_tab.push_back(t_chk(1'b0, 8'h62, 2'd2, data_word(8'h62, 1'b0),
                            mark_word(ST_OVERLONG, 1'b1)));
    dir_tab.push_back(t_chk(1'b0, 8'h63, 2'd0, '0, '0));
    dir_tab.push_back(t_chk(1'b0, CH_LF, 2'd0, '0, '0));
    dir_tab.push_back(t_reg(REG_TRUNCATE, 16'd1));
    dir_tab.push_back(t_word(1'b0, CH_CR));
    dir_tab.push_back(t_word(1'b0, 8'h78));
    dir_tab.push_back(t_chk(1'b0, CH_LF, 2'd0, '0, '0));
    dir_tab.push_back(t_word(1'b0, 8'h79));
    dir_tab.push_back(t_word(1'b1, 8'h00));
    dir_tab.push_back(t_reg(REG_DELIMITER, {8'h00, CH_CR}));
    dir_tab.push_back(t_reg(REG_MAX_LEN, 16'd0));
    dir_tab.push_back(t_chk(1'b0, CH_CR, 2'd1, mark_word(ST_COMPLETE, 1'b1), '0));
    dir_tab.push_back(t_word(1'b0, 8'h7A));
    dir_tab.push_back(t_word(1'b0, CH_CR));
    dir_tab.push_back(t_reg(REG_DELIMITER, {8'h00, CH_LF}));
    dir_tab.push_back(t_reg(REG_STRIP_CR, 16'd1));
    dir_tab.push_back(t_reg(REG_MAX_LEN, 16'd1));
    dir_tab.push_back(t_word(1'b0, CH_CR));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      row = dir_tab[k];
      if (row.op == ROW_REG)
        write_reg(row.reg_idx, row.reg_val);
      else
        send_word(row.eos, row.dat, row.typed, row.n_typed, row.w0, row.w1);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          dlm = 8'h00; stp = 1'b1; mx = 16'd0; trn = 1'b0;
        end
        1: begin
          dlm = 8'hFF; stp = 1'b0; mx = 16'hFFFF; trn = 1'b1;
        end
        default: begin
          r = $urandom_range(0, 3);
          dlm = (r == 0) ? CH_LF : (r == 1) ? CH_CR : 8'($urandom_range(0, 255));
          stp = 1'($urandom_range(0, 1));
          r = $urandom_range(0, 5);
          mx = (r < 2) ? 16'd0 : (r < 5) ? 16'($urandom_range(1, 8))
                                          : 16'($urandom_range(9, 65535));
          trn = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(REG_DELIMITER, {8'h00, dlm});
      write_reg(REG_STRIP_CR, {15'd0, stp});
      write_reg(REG_MAX_LEN, mx);
      write_reg(REG_TRUNCATE, {15'd0, trn});
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 99);
        eos = (r < 4);
        if (r < 4 || r >= 38) d = 8'($urandom_range(0, 255));
        else if (r < 22) d = fr_delim;
        else if (r < 32) d = CH_CR;
        else d = CH_LF;
        if (p == 3 && i == ITEMS_PER_PHASE / 2) drain_results();
        send_word(eos, d, 1'b0, 2'd0, '0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_words.size() != 0)
      report_mismatch("words still expected", 16'(pending_words.size()), 16'd0);
    if (errors == 0)
      $display("** delimited_record_framer_unit: PASSED **");
    else
      $display("** delimited_record_framer_unit: FAILED **");
    $finish;
  end

endmodule

/* delimited_record_framer_unit.f */
+incdir+src
src/drf_pkg.sv
src/drf_front.sv
src/drf_queue.sv
src/drf_back.sv
src/delimited_record_framer_unit.sv
sim/testbench.sv
